/* rtl/pxb_pkg.sv */
package pxb_pkg;

  // Destination pixel layouts
  localparam logic [3:0] FMT_RGB15   = 4'd0;
  localparam logic [3:0] FMT_BGR15   = 4'd1;
  localparam logic [3:0] FMT_RGB15PC = 4'd2;
  localparam logic [3:0] FMT_BGR15PC = 4'd3;
  localparam logic [3:0] FMT_RGB16   = 4'd4;
  localparam logic [3:0] FMT_BGR16   = 4'd5;
  localparam logic [3:0] FMT_RGB16PC = 4'd6;
  localparam logic [3:0] FMT_BGR16PC = 4'd7;
  localparam logic [3:0] FMT_RGB24   = 4'd8;
  localparam logic [3:0] FMT_BGR24   = 4'd9;
  localparam logic [3:0] FMT_ARGB32  = 4'd10;
  localparam logic [3:0] FMT_BGRA32  = 4'd11;
  localparam logic [3:0] FMT_RGBA32  = 4'd12;

  localparam logic [3:0] FMT_RESET = FMT_RGB16;

  // Saturation limits per channel depth
  localparam logic [7:0] MAX_D5 = 8'd31;
  localparam logic [7:0] MAX_D6 = 8'd63;
  localparam logic [7:0] MAX_D8 = 8'd255;

  typedef enum logic [1:0] {
    DEPTH_5 = 2'd0,
    DEPTH_6 = 2'd1,
    DEPTH_8 = 2'd2
  } depth_e;

  // One color channel ready for the blend datapath
  typedef struct packed {
    logic [7:0] src;   // source already reduced to channel depth
    logic [7:0] wgt;   // weight already reduced to channel depth
    logic [7:0] old;   // old channel value, zero extended
    depth_e     depth;
  } lane_t;

  // Per-pixel control carried alongside the lanes
  typedef struct packed {
    logic [3:0]  fmt;
    logic        skip;
    logic [31:0] dst;
  } ctrl_t;

endpackage

/* rtl/pxb_unpack.sv */
module pxb_unpack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [3:0]       fmt_i,
  input  logic [7:0]       src_red_i,
  input  logic [7:0]       src_green_i,
  input  logic [7:0]       src_blue_i,
  input  logic [7:0]       src_weight_i,
  input  logic [31:0]      dst_bytes_i,
  output logic             valid_o,
  output pxb_pkg::lane_t   lane_o [3],
  output pxb_pkg::ctrl_t   ctrl_o
);
  import pxb_pkg::*;

  logic        valid_q;
  lane_t       lane_d [3];
  lane_t       lane_q [3];
  ctrl_t       ctrl_d;
  ctrl_t       ctrl_q;

  logic        wide;
  logic        little;
  logic        bgr;
  logic [15:0] word;
  logic [7:0]  hi_s;
  logic [7:0]  lo_s;
  logic [4:0]  w5;
  logic [5:0]  wg;

  // Split a 15/16-bit word and pick the channel order
  assign wide   = fmt_i[2];
  assign little = fmt_i[1];
  assign bgr    = fmt_i[0];
  assign word   = little ? dst_bytes_i[15:0] : {dst_bytes_i[7:0], dst_bytes_i[15:8]};
  assign hi_s   = bgr ? src_blue_i : src_red_i;
  assign lo_s   = bgr ? src_red_i : src_blue_i;
  assign w5     = src_weight_i[7:3];
  assign wg     = wide ? src_weight_i[7:2] : {1'b0, w5};

  // Decode the layout into three channel lanes
  always_comb begin
    ctrl_d.fmt  = fmt_i;
    ctrl_d.dst  = dst_bytes_i;
    ctrl_d.skip = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lane_d[i] = '{src: 8'd0, wgt: 8'd0, old: 8'd0, depth: DEPTH_8};
    end
    unique case (fmt_i) inside
      [FMT_RGB15:FMT_BGR16PC]: begin
        ctrl_d.skip = wide ? (src_weight_i[7:2] == 6'h3f) : (w5 == 5'h1f);
        lane_d[0].src   = {3'd0, hi_s[7:3]};
        lane_d[0].wgt   = {3'd0, w5};
        lane_d[0].old   = wide ? {3'd0, word[15:11]} : {3'd0, word[14:10]};
        lane_d[0].depth = DEPTH_5;
        lane_d[1].src   = wide ? {2'd0, src_green_i[7:2]} : {3'd0, src_green_i[7:3]};
        lane_d[1].wgt   = {2'd0, wg};
        lane_d[1].old   = wide ? {2'd0, word[10:5]} : {3'd0, word[9:5]};
        lane_d[1].depth = wide ? DEPTH_6 : DEPTH_5;
        lane_d[2].src   = {3'd0, lo_s[7:3]};
        lane_d[2].wgt   = {3'd0, w5};
        lane_d[2].old   = {3'd0, word[4:0]};
        lane_d[2].depth = DEPTH_5;
      end
      FMT_RGB24, FMT_RGBA32, FMT_BGR24, FMT_BGRA32: begin
        ctrl_d.skip = (src_weight_i == 8'hff);
        lane_d[0] = '{src: (fmt_i == FMT_RGB24 || fmt_i == FMT_RGBA32) ? src_red_i
                                                                         : src_blue_i,
                      wgt: src_weight_i, old: dst_bytes_i[7:0], depth: DEPTH_8};
        lane_d[1] = '{src: src_green_i, wgt: src_weight_i, old: dst_bytes_i[15:8],
                      depth: DEPTH_8};
        lane_d[2] = '{src: (fmt_i == FMT_RGB24 || fmt_i == FMT_RGBA32) ? src_blue_i
                                                                         : src_red_i,
                      wgt: src_weight_i, old: dst_bytes_i[23:16], depth: DEPTH_8};
      end
      FMT_ARGB32: begin
        ctrl_d.skip = (src_weight_i == 8'hff);
        lane_d[0] = '{src: src_red_i, wgt: src_weight_i, old: dst_bytes_i[15:8],
                      depth: DEPTH_8};
        lane_d[1] = '{src: src_green_i, wgt: src_weight_i, old: dst_bytes_i[23:16],
                      depth: DEPTH_8};
        lane_d[2] = '{src: src_blue_i, wgt: src_weight_i, old: dst_bytes_i[31:24],
                      depth: DEPTH_8};
      end
      default: begin
        ctrl_d.skip = 1'b1;
      end
    endcase
  end

  // Hold valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Capture the decoded word
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lane_q <= lane_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign ctrl_o  = ctrl_q;

endmodule

/* rtl/pxb_lane.sv */
module pxb_lane (
  input  logic           clk_i,
  input  pxb_pkg::lane_t lane_i,
  output logic [7:0]     res_o
);
  import pxb_pkg::*;

  logic [15:0] prod_q;
  logic [7:0]  src_q;
  depth_e      depth_q;
  logic [7:0]  keep;
  logic [7:0]  maxv;
  logic [8:0]  sum;
  logic [7:0]  res_q;

  // Stage one: weight times old channel
  always_ff @(posedge clk_i) begin
    prod_q  <= {8'd0, lane_i.wgt} * {8'd0, lane_i.old};
    src_q   <= lane_i.src;
    depth_q <= lane_i.depth;
  end

  // Stage two: scale down, add source, clamp to channel maximum
  always_comb begin
    case (depth_q)
      DEPTH_5: begin
        keep = {3'd0, prod_q[9:5]};
        maxv = MAX_D5;
      end
      DEPTH_6: begin
        keep = {2'd0, prod_q[11:6]};
        maxv = MAX_D6;
      end
      default: begin
        keep = prod_q[15:8];
        maxv = MAX_D8;
      end
    endcase
  end

  assign sum = {1'b0, src_q} + {1'b0, keep};

  always_ff @(posedge clk_i) begin
    res_q <= (sum > {1'b0, maxv}) ? maxv : sum[7:0];
  end

  assign res_o = res_q;

endmodule

/* rtl/pxb_pack.sv */
module pxb_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pxb_pkg::ctrl_t ctrl_i,
  input  logic [7:0]     res_i [3],
  output logic           valid_o,
  output logic [31:0]    new_bytes_o,
  output logic           write_enable_o
);
  import pxb_pkg::*;

  logic        valid_q;
  logic [31:0] bytes_d;
  logic [31:0] bytes_q;
  logic        we_q;
  logic [15:0] nw;
  logic [31:0] dst;

  assign dst = ctrl_i.dst;
  assign nw  = ctrl_i.fmt[2] ? {res_i[0][4:0], res_i[1][5:0], res_i[2][4:0]}
                             : {1'b0, res_i[0][4:0], res_i[1][4:0], res_i[2][4:0]};

  // Place the blended channels back into the destination layout
  always_comb begin
    bytes_d = dst;
    if (!ctrl_i.skip) begin
      unique case (ctrl_i.fmt) inside
        [FMT_RGB15:FMT_BGR16PC]: begin
          bytes_d[15:0] = ctrl_i.fmt[1] ? nw : {nw[7:0], nw[15:8]};
        end
        FMT_ARGB32: begin
          bytes_d[31:8] = {res_i[2], res_i[1], res_i[0]};
        end
        FMT_RGB24, FMT_BGR24, FMT_BGRA32, FMT_RGBA32: begin
          bytes_d[23:0] = {res_i[2], res_i[1], res_i[0]};
        end
        default: begin
          bytes_d = dst;
        end
      endcase
    end
  end

  // Advance the output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      bytes_q <= bytes_d;
      we_q    <= !ctrl_i.skip;
    end
  end

  assign valid_o        = valid_q;
  assign new_bytes_o    = bytes_q;
  assign write_enable_o = we_q;

endmodule

/* rtl/premultiplied_pixel_blend.sv */
// A word taken with start appears on new_valid_o after the four register stages named below.
// Throughput: one pixel per clock; four register stages (decode, multiply,
// add and clamp, repack) each hold one pixel, so busy stays low.
// The receiver cannot stall.
// Reset clears all valid bits and sets pixel_format to RGB16.
module premultiplied_pixel_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  src_red_i,
  input  logic [7:0]  src_green_i,
  input  logic [7:0]  src_blue_i,
  input  logic [7:0]  src_weight_i,
  input  logic [31:0] dst_bytes_i,
  output logic        new_valid_o,
  output logic [31:0] new_bytes_o,
  output logic        write_enable_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_pixel_format_i
);
  import pxb_pkg::*;

  logic [3:0] fmt_q;
  logic       accept;
  logic       s1_valid;
  lane_t      s1_lane [3];
  ctrl_t      s1_ctrl;
  logic       s2_valid_q;
  logic       s3_valid_q;
  ctrl_t      s2_ctrl_q;
  ctrl_t      s3_ctrl_q;
  logic [7:0] lane_res [3];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Hold the pixel format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= cfg_pixel_format_i;
    end
  end

  pxb_unpack u_unpack (
    .clk_i,
    .rst_ni,
    .valid_i      (accept),
    .fmt_i        (fmt_q),
    .src_red_i,
    .src_green_i,
    .src_blue_i,
    .src_weight_i,
    .dst_bytes_i,
    .valid_o      (s1_valid),
    .lane_o       (s1_lane),
    .ctrl_o       (s1_ctrl)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pxb_lane u_lane (
      .clk_i,
      .lane_i (s1_lane[i]),
      .res_o  (lane_res[i])
    );
  end

  // Advance valid bits alongside the two lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctrl_q <= s1_ctrl;
    s3_ctrl_q <= s2_ctrl_q;
  end

  pxb_pack u_pack (
    .clk_i,
    .rst_ni,
    .valid_i        (s3_valid_q),
    .ctrl_i         (s3_ctrl_q),
    .res_i          (lane_res),
    .valid_o        (new_valid_o),
    .new_bytes_o,
    .write_enable_o
  );

endmodule
